// ----- hdl/block_table_allocator_defines.svh -----
// ---------------------------------------------------------------------------
// block_table_allocator_defines
// Assertion macros shared by the allocator RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef BLOCK_TABLE_ALLOCATOR_DEFINES_SVH
`define BLOCK_TABLE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define BTA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("allocator assertion failed");

// antecedent implies consequent in the same cycle
`define BTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator implication failed");

`else

`define BTA_ASSERT(lbl, clk, rst_n, prop)
`define BTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/bta_pkg.sv -----
// ---------------------------------------------------------------------------
// bta_pkg
// Shared constants and codes of the block table allocator.
// ---------------------------------------------------------------------------
package bta_pkg;

	// default pool geometry
	localparam int NUM_BLOCKS_DEF  = 256;
	localparam int BLOCK_BYTES_DEF = 32;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int SIZE_W   = 14;
	localparam int OFF_IN_W = 14;
	localparam int STATUS_W = 2;
	localparam int AOFF_W   = 13;
	localparam int PCT_W    = 7;

	// scale of the usage figure
	localparam int PCT_SCALE = 100;

	// default map entry geometry for the generic ram
	localparam int RAM_WIDTH_DEF = 9;
	localparam int RAM_DEPTH_DEF = 256;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_INIT  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_READY  = 2'd1,
		ST_ADDR_ERR   = 2'd2,
		ST_ALLOC_FAIL = 2'd3
	} status_t;

endpackage

// ----- hdl/block_table_allocator.sv -----
// Per request: allocate clears the map when not yet ready, scans at one entry per cycle and
// marks each block of the run; free reads and clears the entries of the run (clears the map
// and reports not ready before ready); query computes the usage figure; initialize clears
// the map. One item at a time; the next beat can be taken in the cycle after the result
// enters the output register. Reset clears control state, then sweeps the map to zero.
// ---------------------------------------------------------------------------
// block_table_allocator
// Top-down first-fit block allocator over a map memory with one run count per block.
// ---------------------------------------------------------------------------
`include "block_table_allocator_defines.svh"

module block_table_allocator #(
	parameter int NUM_BLOCKS  = bta_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = bta_pkg::BLOCK_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bta_pkg::OP_W-1:0]     opcode,
	input  logic [bta_pkg::SIZE_W-1:0]   byte_size,
	input  logic [bta_pkg::OFF_IN_W-1:0] byte_offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bta_pkg::STATUS_W-1:0] status,
	output logic [bta_pkg::AOFF_W-1:0]   alloc_offset,
	output logic [bta_pkg::PCT_W-1:0]    usage_percent
);

	// geometry
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int SIZE_MAX   = (1 << bta_pkg::SIZE_W) - 1;
	localparam int NEED_DVD_W = $clog2(SIZE_MAX + BLOCK_BYTES);
	localparam int DIV_W      = (NEED_DVD_W > bta_pkg::OFF_IN_W) ? NEED_DVD_W : bta_pkg::OFF_IN_W;
	localparam int NEED_W     = $clog2((SIZE_MAX + BLOCK_BYTES - 1) / BLOCK_BYTES + 1);
	localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
	localparam int PROD_W0    = BLK_W + $clog2(BLOCK_BYTES + 1);
	localparam int PROD_W     = (PROD_W0 > bta_pkg::AOFF_W) ? PROD_W0 : bta_pkg::AOFF_W;
	localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

	// reciprocal constants: floor(n * M / 2^S) equals floor(n / d) over the dividend range
	localparam int     BQ_S  = DIV_W + $clog2(BLOCK_BYTES);
	localparam longint BQ_M  = ((longint'(1) << BQ_S) + longint'(BLOCK_BYTES - 1))
		/ longint'(BLOCK_BYTES);
	localparam int     BQ_PW = 2 * DIV_W + 2;
	localparam int     PQ_N  = $clog2(NUM_BLOCKS * bta_pkg::PCT_SCALE + 1);
	localparam int     PQ_S  = PQ_N + $clog2(NUM_BLOCKS);
	localparam longint PQ_K  = (((longint'(1) << PQ_S) + longint'(NUM_BLOCKS - 1))
		/ longint'(NUM_BLOCKS)) * longint'(bta_pkg::PCT_SCALE);
	localparam int     PQ_PW = CNT_W + $clog2(PQ_K + 1);

	typedef enum logic [11:0] {
		S_RST_CLR  = 12'b0000_0000_0001,
		S_IDLE     = 12'b0000_0000_0010,
		S_DISPATCH = 12'b0000_0000_0100,
		S_CLR      = 12'b0000_0000_1000,
		S_PREP     = 12'b0000_0001_0000,
		S_DIV      = 12'b0000_0010_0000,
		S_DIV_END  = 12'b0000_0100_0000,
		S_SCAN     = 12'b0000_1000_0000,
		S_MARK     = 12'b0001_0000_0000,
		S_REL_RD   = 12'b0010_0000_0000,
		S_REL_WR   = 12'b0100_0000_0000,
		S_FIN      = 12'b1000_0000_0000
	} state_t;

	state_t                        state_q;
	logic                          ready_q;
	logic [CNT_W-1:0]              used_q;
	bta_pkg::opcode_t              op_q;
	logic [bta_pkg::SIZE_W-1:0]    size_q;
	logic [bta_pkg::OFF_IN_W-1:0]  off_q;
	logic [BLK_W-1:0]              addr_q;
	logic [CNT_W-1:0]              left_q;
	logic                          head_q;
	logic [CNT_W-1:0]              need_q;

	// scan pipeline
	logic [BLK_W-1:0]              rd_addr_q;
	logic                          issue_done_q;
	logic                          pend_q;
	logic [BLK_W-1:0]              tag_q;
	logic [CNT_W-1:0]              run_q;

	// constant-divisor quotient
	logic [DIV_W-1:0]              div_dvd_q;
	logic [DIV_W-1:0]              div_quo_q;
	logic                          div_sel_q;

	// pending result
	bta_pkg::status_t              res_status_q;
	logic [bta_pkg::AOFF_W-1:0]    res_aoff_q;
	logic [bta_pkg::PCT_W-1:0]     res_pct_q;

	// output register
	logic                          out_valid_q;
	logic [bta_pkg::STATUS_W-1:0]  out_status_q;
	logic [bta_pkg::AOFF_W-1:0]    out_aoff_q;
	logic [bta_pkg::PCT_W-1:0]     out_pct_q;

	// map memory ports
	logic                          mem_we;
	logic [BLK_W-1:0]              mem_waddr;
	logic [CNT_W-1:0]              mem_wdata;
	logic                          mem_re;
	logic [BLK_W-1:0]              mem_raddr;
	logic [CNT_W-1:0]              mem_rdata;

	logic [BQ_PW-1:0]              blk_prod;
	logic [PQ_PW-1:0]              pct_prod;
	logic [NEED_W-1:0]             need_full;
	logic [CNT_W-1:0]              run_nx;
	logic [CNT_W-1:0]              left_nx;
	logic [PROD_W-1:0]             aoff_prod;
	logic                          out_free;

	bta_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// quotients by reciprocal multiplication
	assign blk_prod  = BQ_PW'(div_dvd_q) * BQ_PW'(BQ_M);
	assign pct_prod  = PQ_PW'(used_q) * PQ_PW'(PQ_K);
	assign need_full = div_quo_q[NEED_W-1:0];

	// scan run length and release count
	assign run_nx    = (mem_rdata == '0) ? (run_q + CNT_W'(1)) : '0;
	assign left_nx   = head_q ? mem_rdata : left_q;
	assign aoff_prod = PROD_W'(tag_q) * PROD_W'(BLOCK_BYTES);

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	// map memory access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		unique case (state_q)
			S_RST_CLR, S_CLR: begin
				mem_we = 1'b1;
			end
			S_SCAN: begin
				mem_re    = !issue_done_q;
				mem_raddr = rd_addr_q;
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = need_q;
			end
			S_REL_RD: begin
				mem_re = 1'b1;
			end
			S_REL_WR: begin
				mem_we = (left_nx != '0);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_RST_CLR;
			ready_q      <= 1'b0;
			used_q       <= '0;
			op_q         <= bta_pkg::OP_ALLOC;
			size_q       <= '0;
			off_q        <= '0;
			addr_q       <= '0;
			left_q       <= '0;
			head_q       <= 1'b0;
			need_q       <= '0;
			rd_addr_q    <= '0;
			issue_done_q <= 1'b0;
			pend_q       <= 1'b0;
			tag_q        <= '0;
			run_q        <= '0;
			div_dvd_q    <= '0;
			div_quo_q    <= '0;
			div_sel_q    <= 1'b0;
			res_status_q <= bta_pkg::ST_OK;
			res_aoff_q   <= '0;
			res_pct_q    <= '0;
		end else begin
			unique case (state_q)
				// power-up sweep of the map
				S_RST_CLR: begin
					addr_q <= addr_q + BLK_W'(1);
					if (addr_q == LAST_BLK) begin
						state_q <= S_IDLE;
					end
				end
				// take one input beat
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= bta_pkg::opcode_t'(opcode);
						size_q  <= byte_size;
						off_q   <= byte_offset;
						state_q <= S_DISPATCH;
					end
				end
				// decode the request
				S_DISPATCH: begin
					res_status_q <= bta_pkg::ST_OK;
					res_aoff_q   <= '0;
					res_pct_q    <= '0;
					addr_q       <= '0;
					unique case (op_q)
						bta_pkg::OP_ALLOC: begin
							state_q <= ready_q ? S_PREP : S_CLR;
						end
						bta_pkg::OP_FREE: begin
							if (!ready_q) begin
								state_q <= S_CLR;
							end else if (32'(off_q) >= POOL_BYTES) begin
								res_status_q <= bta_pkg::ST_ADDR_ERR;
								state_q      <= S_FIN;
							end else begin
								div_dvd_q <= DIV_W'(off_q);
								div_sel_q <= 1'b0;
								state_q   <= S_DIV;
							end
						end
						bta_pkg::OP_QUERY: begin
							div_sel_q <= 1'b1;
							state_q   <= S_DIV;
						end
						bta_pkg::OP_INIT: begin
							state_q <= S_CLR;
						end
					endcase
				end
				// clear the map, then mark ready
				S_CLR: begin
					addr_q <= addr_q + BLK_W'(1);
					if (addr_q == LAST_BLK) begin
						ready_q <= 1'b1;
						used_q  <= '0;
						unique case (op_q)
							bta_pkg::OP_ALLOC: begin
								state_q <= S_PREP;
							end
							bta_pkg::OP_FREE: begin
								res_status_q <= bta_pkg::ST_NOT_READY;
								state_q      <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				// reject a zero size, else round the size up to whole blocks
				S_PREP: begin
					if (size_q == '0) begin
						res_status_q <= bta_pkg::ST_ALLOC_FAIL;
						state_q      <= S_FIN;
					end else begin
						div_dvd_q <= DIV_W'(size_q) + DIV_W'(BLOCK_BYTES - 1);
						div_sel_q <= 1'b0;
						state_q   <= S_DIV;
					end
				end
				// register the quotient
				S_DIV: begin
					div_quo_q <= div_sel_q ? DIV_W'(pct_prod[PQ_PW-1:PQ_S])
						: DIV_W'(blk_prod[BQ_PW-1:BQ_S]);
					state_q   <= S_DIV_END;
				end
				// use the quotient
				S_DIV_END: begin
					unique case (op_q)
						bta_pkg::OP_ALLOC: begin
							if (32'(need_full) > NUM_BLOCKS) begin
								res_status_q <= bta_pkg::ST_ALLOC_FAIL;
								state_q      <= S_FIN;
							end else begin
								need_q       <= CNT_W'(need_full);
								rd_addr_q    <= LAST_BLK;
								issue_done_q <= 1'b0;
								pend_q       <= 1'b0;
								run_q        <= '0;
								state_q      <= S_SCAN;
							end
						end
						bta_pkg::OP_FREE: begin
							addr_q  <= div_quo_q[BLK_W-1:0];
							head_q  <= 1'b1;
							state_q <= S_REL_RD;
						end
						bta_pkg::OP_QUERY: begin
							res_pct_q <= div_quo_q[bta_pkg::PCT_W-1:0];
							state_q   <= S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				// top-down scan: issue one read per cycle, count the free run
				S_SCAN: begin
					if (!issue_done_q) begin
						tag_q  <= rd_addr_q;
						pend_q <= 1'b1;
						if (rd_addr_q == '0) begin
							issue_done_q <= 1'b1;
						end else begin
							rd_addr_q <= rd_addr_q - BLK_W'(1);
						end
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						run_q <= run_nx;
						if (run_nx == need_q) begin
							addr_q     <= tag_q;
							left_q     <= need_q;
							used_q     <= used_q + need_q;
							res_aoff_q <= aoff_prod[bta_pkg::AOFF_W-1:0];
							state_q    <= S_MARK;
						end else if (tag_q == '0) begin
							res_status_q <= bta_pkg::ST_ALLOC_FAIL;
							state_q      <= S_FIN;
						end
					end
				end
				// write the run length into each block of the run
				S_MARK: begin
					addr_q <= addr_q + BLK_W'(1);
					left_q <= left_q - CNT_W'(1);
					if (left_q == CNT_W'(1)) begin
						state_q <= S_FIN;
					end
				end
				// release: read the entry
				S_REL_RD: begin
					state_q <= S_REL_WR;
				end
				// release: clear it, stop at the count or the end of the map
				S_REL_WR: begin
					head_q <= 1'b0;
					if (left_nx == '0) begin
						state_q <= S_FIN;
					end else begin
						if (mem_rdata != '0) begin
							used_q <= used_q - CNT_W'(1);
						end
						left_q <= left_nx - CNT_W'(1);
						if ((left_nx == CNT_W'(1)) || (addr_q == LAST_BLK)) begin
							state_q <= S_FIN;
						end else begin
							addr_q  <= addr_q + BLK_W'(1);
							state_q <= S_REL_RD;
						end
					end
				end
				// hand the result to the output register
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			out_status_q <= res_status_q;
			out_aoff_q   <= res_aoff_q;
			out_pct_q    <= res_pct_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign alloc_offset  = out_aoff_q;
	assign usage_percent = out_pct_q;

	// checks
	`BTA_ASSERT_IMP(a_scan_no_write, clk, arst_n, state_q == S_SCAN, !mem_we)
	`BTA_ASSERT(a_used_range, clk, arst_n, 32'(used_q) <= NUM_BLOCKS)
	`BTA_ASSERT_IMP(a_out_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q == S_FIN))
	`BTA_ASSERT_IMP(a_mark_nonzero, clk, arst_n, state_q == S_MARK, need_q != '0)

endmodule

// ----- hdl/bta_ram.sv -----
// ---------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = bta_pkg::RAM_WIDTH_DEF,
	parameter int DEPTH = bta_pkg::RAM_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for block_table_allocator. A short table of directed
// requests covers the reset state, pool extremes and every status code. A
// long random run of allocate, free, query and initialize requests follows.
// Frees mostly target live allocations. Every result beat is compared
// against a typed row's reply or the bench's map model. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module tb;
	import bta_pkg::*;

	localparam int NBLK    = NUM_BLOCKS_DEF;
	localparam int BBYTES  = BLOCK_BYTES_DEF;
	localparam int POOL    = NBLK * BBYTES;
	localparam int N_RAND  = 1700;
	localparam int N_DIR   = 24;
	localparam int DRAIN   = 2 * NBLK + 64;

	typedef struct packed {
		status_t             st;
		logic [AOFF_W-1:0]   aoff;
		logic [PCT_W-1:0]    pct;
	} reply_t;

	typedef struct packed {
		opcode_t             op;
		logic [SIZE_W-1:0]   sz;
		logic [OFF_IN_W-1:0] off;
		bit                  typed;
		reply_t              want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     opcode = '0;
	logic [SIZE_W-1:0]   byte_size = '0;
	logic [OFF_IN_W-1:0] byte_offset = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [AOFF_W-1:0]   alloc_offset;
	logic [PCT_W-1:0]    usage_percent;

	// model of the block map
	logic [RAM_WIDTH_DEF-1:0] run_map [NBLK];
	bit                       map_ready = 1'b0;
	int                       live_starts [$];

	reply_t pending_replies [$];
	int     n_fail = 0;
	int     beats_sent = 0;
	bit     in_calm = 1'b0;

	// directed requests; typed rows carry their reply, others use the model
	dir_row_t dir_rows [N_DIR] = '{
		'{OP_QUERY, 14'd0,     14'd0,     1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'd0,     1'b1, '{ST_NOT_READY,  13'd0,    7'd0}},
		'{OP_ALLOC, 14'd0,     14'h3fff,  1'b1, '{ST_ALLOC_FAIL, 13'd0,    7'd0}},
		'{OP_ALLOC, 14'd1,     14'd0,     1'b1, '{ST_OK,         13'd8160, 7'd0}},
		'{OP_ALLOC, 14'd32,    14'd0,     1'b1, '{ST_OK,         13'd8128, 7'd0}},
		'{OP_ALLOC, 14'd33,    14'd0,     1'b0, '{ST_OK,         13'd0,    7'd0}},
		'{OP_QUERY, 14'h3fff,  14'h3fff,  1'b0, '{ST_OK,         13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'h3fff,  1'b1, '{ST_ADDR_ERR,   13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'd8192,  1'b1, '{ST_ADDR_ERR,   13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'd8191,  1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'd8191,  1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'd8096,  1'b0, '{ST_OK,         13'd0,    7'd0}},
		'{OP_ALLOC, 14'd8192,  14'd0,     1'b0, '{ST_OK,         13'd0,    7'd0}},
		'{OP_INIT,  14'h3fff,  14'h3fff,  1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_ALLOC, 14'd8192,  14'd0,     1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_QUERY, 14'd0,     14'd0,     1'b1, '{ST_OK,         13'd0,    7'd100}},
		'{OP_ALLOC, 14'd1,     14'd0,     1'b1, '{ST_ALLOC_FAIL, 13'd0,    7'd0}},
		'{OP_FREE,  14'd0,     14'd31,    1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_QUERY, 14'd0,     14'd0,     1'b1, '{ST_OK,         13'd0,    7'd0}},
		'{OP_ALLOC, 14'h3fff,  14'd0,     1'b1, '{ST_ALLOC_FAIL, 13'd0,    7'd0}},
		'{OP_ALLOC, 14'd8193,  14'd0,     1'b1, '{ST_ALLOC_FAIL, 13'd0,    7'd0}},
		'{OP_ALLOC, 14'd8160,  14'd0,     1'b1, '{ST_OK,         13'd32,   7'd0}},
		'{OP_FREE,  14'd0,     14'd8191,  1'b0, '{ST_OK,         13'd0,    7'd0}},
		'{OP_QUERY, 14'd0,     14'd0,     1'b0, '{ST_OK,         13'd0,    7'd0}}
	};

	block_table_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.byte_size     (byte_size),
		.byte_offset   (byte_offset),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.alloc_offset  (alloc_offset),
		.usage_percent (usage_percent)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// clear every map entry and mark the pool usable
	function automatic void wipe_map();
		for (int b = 0; b < NBLK; b++)
			run_map[b] = '0;
		map_ready = 1'b1;
		live_starts.delete();
	endfunction

	// apply one request to the map model and return the reply it should give
	function automatic reply_t apply_request(opcode_t op, logic [SIZE_W-1:0] sz,
			logic [OFF_IN_W-1:0] off);
		reply_t r;
		int     need;
		int     run;
		int     blk;
		int     cnt;
		int     used;
		r = '{ST_OK, '0, '0};
		case (op)
			OP_ALLOC: begin
				if (!map_ready)
					wipe_map();
				need = (int'(sz) + BBYTES - 1) / BBYTES;
				r.st = ST_ALLOC_FAIL;
				if (need != 0 && need <= NBLK) begin
					// top-down first fit
					blk = NBLK;
					run = 0;
					while (blk > 0 && run < need) begin
						blk--;
						run = (run_map[blk] == '0) ? run + 1 : 0;
					end
					if (run == need) begin
						for (int i = 0; i < need; i++)
							run_map[blk + i] = RAM_WIDTH_DEF'(need);
						r.st   = ST_OK;
						r.aoff = AOFF_W'(blk * BBYTES);
						live_starts.push_back(blk);
					end
				end
			end
			OP_FREE: begin
				if (!map_ready) begin
					wipe_map();
					r.st = ST_NOT_READY;
				end else if (int'(off) >= POOL) begin
					r.st = ST_ADDR_ERR;
				end else begin
					// clear the count found here, cut off at the table end
					blk = int'(off) / BBYTES;
					cnt = int'(run_map[blk]);
					for (int i = 0; i < cnt && blk + i < NBLK; i++)
						run_map[blk + i] = '0;
				end
			end
			OP_QUERY: begin
				used = 0;
				for (int b = 0; b < NBLK; b++)
					if (run_map[b] != '0)
						used++;
				r.pct = PCT_W'(used * PCT_SCALE / NBLK);
			end
			default: begin
				wipe_map();
			end
		endcase
		return r;
	endfunction

	// drive one request beat and record its reply once it is taken
	task automatic send_request(opcode_t op, logic [SIZE_W-1:0] sz,
			logic [OFF_IN_W-1:0] off, bit typed, reply_t typed_reply);
		int     gap;
		reply_t r;
		if (beats_sent % 64 == 0)
			in_calm = ($urandom_range(3, 0) == 0);
		gap = in_calm ? 0 : $urandom_range(11, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		byte_size   <= sz;
		byte_offset <= off;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		r = apply_request(op, sz, off);
		pending_replies.push_back(typed ? typed_reply : r);
		beats_sent++;
	endtask

	// result side: random stalls per beat, with stall-free stretches
	initial begin : drive_out_ready
		int  stall;
		int  taken;
		bit  out_calm;
		taken    = 0;
		out_calm = 1'b0;
		wait (arst_n);
		forever begin
			if (taken % 64 == 0)
				out_calm = ($urandom_range(3, 0) == 0);
			stall = out_calm ? 0 : $urandom_range(11, 0);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && out_ready));
			taken++;
		end
	end

	// compare each result beat with the oldest pending reply
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$error("result beat with no request outstanding");
				n_fail++;
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					n_fail++;
				end
				if (alloc_offset !== want.aoff) begin
					$error("alloc_offset: expected %0d, got %0d", want.aoff, alloc_offset);
					n_fail++;
				end
				if (usage_percent !== want.pct) begin
					$error("usage_percent: expected %0d, got %0d", want.pct,
						usage_percent);
					n_fail++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int                  pick;
		int                  idx;
		int                  blk;
		opcode_t             op;
		logic [SIZE_W-1:0]   sz;
		logic [OFF_IN_W-1:0] off;
		reply_t              none;
		none = '{ST_OK, '0, '0};
		for (int b = 0; b < NBLK; b++)
			run_map[b] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int k = 0; k < N_DIR; k++)
			send_request(dir_rows[k].op, dir_rows[k].sz, dir_rows[k].off,
				dir_rows[k].typed, dir_rows[k].want);

		// random requests, mostly alloc and free of live regions
		for (int k = 0; k < N_RAND; k++) begin
			if (k == N_RAND / 2) begin
				// let the block drain completely once
				in_valid <= 1'b0;
				while (pending_replies.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(99, 0);
			sz   = SIZE_W'($urandom);
			off  = OFF_IN_W'($urandom);
			if (pick < 45) begin
				op   = OP_ALLOC;
				pick = $urandom_range(99, 0);
				if (pick < 70)
					sz = SIZE_W'($urandom_range(256, 1));
				else if (pick < 90)
					sz = SIZE_W'($urandom_range(2048, 257));
				else if (pick < 97)
					sz = SIZE_W'($urandom_range(16383, 2049));
				else
					sz = '0;
			end else if (pick < 82) begin
				op   = OP_FREE;
				pick = $urandom_range(99, 0);
				if (pick < 75 && live_starts.size() != 0) begin
					idx = $urandom_range(live_starts.size() - 1, 0);
					blk = live_starts[idx];
					live_starts.delete(idx);
					off = OFF_IN_W'(blk * BBYTES + $urandom_range(BBYTES - 1, 0));
				end else if (pick < 90) begin
					off = OFF_IN_W'($urandom_range(POOL - 1, 0));
				end else begin
					off = OFF_IN_W'($urandom_range(16383, POOL));
				end
			end else if (pick < 98) begin
				op = OP_QUERY;
			end else begin
				op = OP_INIT;
			end
			send_request(op, sz, off, 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// overall time limit
	initial begin
		#60_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bta_pkg.sv
hdl/bta_ram.sv
hdl/block_table_allocator.sv
verif/tb.sv
